// ===== sv/assert_macros.svh =====
// Assertion macros for the deque engine checks.
// No dependencies; the macros use clk and rst_n of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset
`define BDE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deque engine check failed");
// Condition in one cycle implies a consequence in the next
`define BDE_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("deque engine check failed");
`else
`define BDE_ASSERT(label, prop)
`define BDE_ASSERT_NEXT(label, cond, conseq)
`endif
`endif

// ===== sv/bde_pkg.sv =====
// Shared types and constants for the bounded deque engine.
// No dependencies.
package bde_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int REQ_W    = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd4;

    // operation broadcast to every cell (already gated by full/empty)
    typedef struct packed {
        logic              ins_front;
        logic              ins_back;
        logic              rem_front;
        logic              rem_back;
        logic              clear;
        logic [WORD_W-1:0] value;
    } cell_ctl_t;

    // word handed between neighboring cells
    typedef struct packed {
        logic              occ;
        logic [WORD_W-1:0] data;
    } cell_link_t;

endpackage

// ===== sv/bde_cell.sv =====
// One deque cell: holds a word and an occupied flag, shifts with neighbors.
// Depends on bde_pkg.
module bde_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bde_pkg::cell_ctl_t        ctl,
    input  bde_pkg::cell_link_t       left_in,
    input  bde_pkg::cell_link_t       right_in,
    output bde_pkg::cell_link_t       self_out,
    input  logic [bde_pkg::WORD_W-1:0] back_in,
    output logic [bde_pkg::WORD_W-1:0] back_out
);
    import bde_pkg::*;

    logic              occ_reg;
    logic              occ_next;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    // next-state: shift toward back on front insert, toward front on front removal
    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (ctl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctl.ins_front)
        begin
            occ_next  = left_in.occ;
            data_next = left_in.data;
        end
        else if (ctl.ins_back)
        begin
            // first free slot after the occupied prefix
            if (!occ_reg && left_in.occ)
            begin
                occ_next  = 1'b1;
                data_next = ctl.value;
            end
        end
        else if (ctl.rem_front)
        begin
            occ_next  = right_in.occ;
            data_next = right_in.data;
        end
        else if (ctl.rem_back)
        begin
            if (occ_reg && !right_in.occ)
            begin
                occ_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign self_out.occ  = occ_reg;
    assign self_out.data = data_reg;

    // the last occupied cell claims the back word, others pass it on
    assign back_out = (occ_reg && !right_in.occ) ? data_reg : back_in;

endmodule

// ===== sv/bounded_deque_engine_core.sv =====
// Top level of the bounded deque engine: request decode, count and result strobe.
// Depends on bde_pkg, bde_cell and assert_macros.svh.
//
//  channel   | handshake        | words
//  ----------+------------------+-----------------------------------------------
//  request   | start / busy     | req_type, item_value
//  result    | done (strobe)    | front_value, back_value, entry_count, status
//
// A request is taken when start is high; its result is strobed on done the next cycle.
// busy stays low, so a new request may be taken every cycle, including while
// the previous result is shown. Reset clears the occupied flags and the count;
// the cell words stay undefined until written. The receiver cannot stall.
`include "assert_macros.svh"
module bounded_deque_engine_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bde_pkg::REQ_W-1:0]          req_type,
    input  logic signed [bde_pkg::WORD_W-1:0]  item_value,
    output logic                               done,
    output logic signed [bde_pkg::WORD_W-1:0]  front_value,
    output logic signed [bde_pkg::WORD_W-1:0]  back_value,
    output logic [bde_pkg::COUNT_W-1:0]        entry_count,
    output logic                               status
);
    import bde_pkg::*;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 drop;
    cell_ctl_t            ctl;
    cell_link_t           links [CAPACITY];
    logic [WORD_W-1:0]    back_chain [CAPACITY+1];
    logic [CAPACITY-1:0]  occ_vec;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 done_reg;
    logic                 status_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign empty  = !links[0].occ;
    assign full   = links[CAPACITY-1].occ;

    // request decode, gated by full and empty
    always_comb
    begin
        ctl        = '0;
        ctl.value  = item_value;
        drop       = 1'b0;
        count_next = count_reg;
        if (accept)
        begin
            unique case (req_type) inside
                REQ_INS_FRONT, REQ_INS_BACK:
                begin
                    if (full)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        ctl.ins_front = (req_type == REQ_INS_FRONT);
                        ctl.ins_back  = (req_type == REQ_INS_BACK);
                        count_next    = count_reg + COUNT_W'(1);
                    end
                end
                REQ_REM_FRONT, REQ_REM_BACK:
                begin
                    if (!empty)
                    begin
                        ctl.rem_front = (req_type == REQ_REM_FRONT);
                        ctl.rem_back  = (req_type == REQ_REM_BACK);
                        count_next    = count_reg - COUNT_W'(1);
                    end
                end
                REQ_CLEAR:
                begin
                    ctl.clear  = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    ctl.clear = 1'b0;
                end
            endcase
        end
    end

    // row of cells, front at index 0
    assign back_chain[CAPACITY] = '0;
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_link_t left_l;
            cell_link_t right_l;
            if (gi == 0)
            begin : g_head
                // the head sees the new word as an occupied left neighbor
                assign left_l.occ  = 1'b1;
                assign left_l.data = item_value;
            end
            else
            begin : g_mid
                assign left_l = links[gi-1];
            end
            if (gi == CAPACITY-1)
            begin : g_tail
                assign right_l = '0;
            end
            else
            begin : g_body
                assign right_l = links[gi+1];
            end
            bde_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .left_in  (left_l),
                .right_in (right_l),
                .self_out (links[gi]),
                .back_in  (back_chain[gi+1]),
                .back_out (back_chain[gi])
            );
            assign occ_vec[gi] = links[gi].occ;
        end
    endgenerate

    // count, strobe and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= drop;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign front_value = links[0].occ ? links[0].data : '0;
    assign back_value  = back_chain[0];

    // checks
    `BDE_ASSERT(a_empty_count, ((count_reg == '0) == !links[0].occ))
    `BDE_ASSERT(a_occ_prefix, ((occ_vec & (occ_vec + CAPACITY'(1))) == '0))
    `BDE_ASSERT(a_full_count, ((count_reg == COUNT_W'(CAPACITY)) == full))
    `BDE_ASSERT_NEXT(a_done_follows, accept, done)

endmodule
